/* sv/gtg_pkg.sv */
`default_nettype none

package gtg_pkg;

    // Datapath widths of the vectoring rotator
    localparam int unsigned XW = 28;
    localparam int unsigned ZW = 34;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned ATAN_LEN         = 24;

    localparam logic signed [ZW-1:0] PI_Q29     = 34'sd1686629713;
    localparam logic [15:0]          GAIN_CORR  = 16'd39797;

    // Register reset values
    localparam logic signed [15:0] GOAL_X_RST   = 16'sd256;
    localparam logic signed [15:0] GOAL_Y_RST   = 16'sd256;
    localparam logic [11:0]        LIN_GAIN_RST = 12'd384;
    localparam logic [11:0]        ANG_GAIN_RST = 12'd1024;
    localparam logic [15:0]        TOL_RST      = 16'd3;

    typedef enum logic [2:0] {
        CFG_GOAL_X   = 3'd0,
        CFG_GOAL_Y   = 3'd1,
        CFG_LIN_GAIN = 3'd2,
        CFG_ANG_GAIN = 3'd3,
        CFG_TOL      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [11:0]        linear_gain;
        logic [11:0]        angular_gain;
        logic [15:0]        arrive_tolerance;
    } t_cfg;

    // One beat moving down the rotator chain
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [15:0]   hd;
    } t_cord;

    // atan(2^-i) in Q3.29
    function automatic logic signed [ZW-1:0] atan_q29(input int unsigned i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 34'sd421657428;
            1:       v = 34'sd248918915;
            2:       v = 34'sd131521918;
            3:       v = 34'sd66762579;
            4:       v = 34'sd33510843;
            5:       v = 34'sd16771758;
            6:       v = 34'sd8387925;
            7:       v = 34'sd4194219;
            8:       v = 34'sd2097141;
            9:       v = 34'sd1048575;
            10:      v = 34'sd524288;
            11:      v = 34'sd262144;
            12:      v = 34'sd131072;
            13:      v = 34'sd65536;
            14:      v = 34'sd32768;
            15:      v = 34'sd16384;
            16:      v = 34'sd8192;
            17:      v = 34'sd4096;
            18:      v = 34'sd2048;
            19:      v = 34'sd1024;
            20:      v = 34'sd512;
            21:      v = 34'sd256;
            22:      v = 34'sd128;
            23:      v = 34'sd64;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/go_to_goal_p_controller.sv */
`default_nettype none

// Channel   Handshake          Payload
// pose in   i_valid/o_ready    i_pos_x, i_pos_y, i_heading
// cmd out   o_valid/i_ready    o_linear_cmd, o_angular_cmd, o_reached
// config    i_cfg_wr_en        i_cfg_idx, i_cfg_data (write only)
//
// One pose enters per cycle while o_ready is high; each passes through one
// folding stage, one rotator cell per step and four scaling stages.
// Every stage moves its beat on when its successor is empty or moving, so a
// stalled output only backs up as far as the first empty stage.
// Reset clears all stage valid bits and loads the register defaults.

module go_to_goal_p_controller #(
    parameter int unsigned CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_pos_x,
    input  wire logic [15:0] i_pos_y,
    input  wire logic [15:0] i_heading,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_linear_cmd,
    output logic [15:0]      o_angular_cmd,
    output logic             o_reached
);

    gtg_pkg::t_cfg   r_cfg;
    gtg_pkg::t_cfg   n_cfg;

    logic            link_valid [CORDIC_STEPS+1];
    logic            link_ready [CORDIC_STEPS+1];
    gtg_pkg::t_cord  link_data  [CORDIC_STEPS+1];

    // Apply a register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                gtg_pkg::CFG_GOAL_X:   n_cfg.goal_x           = i_cfg_data;
                gtg_pkg::CFG_GOAL_Y:   n_cfg.goal_y           = i_cfg_data;
                gtg_pkg::CFG_LIN_GAIN: n_cfg.linear_gain      = i_cfg_data[11:0];
                gtg_pkg::CFG_ANG_GAIN: n_cfg.angular_gain     = i_cfg_data[11:0];
                gtg_pkg::CFG_TOL:      n_cfg.arrive_tolerance = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x           <= gtg_pkg::GOAL_X_RST;
            r_cfg.goal_y           <= gtg_pkg::GOAL_Y_RST;
            r_cfg.linear_gain      <= gtg_pkg::LIN_GAIN_RST;
            r_cfg.angular_gain     <= gtg_pkg::ANG_GAIN_RST;
            r_cfg.arrive_tolerance <= gtg_pkg::TOL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Fold the goal vector into the right half plane
    gtg_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_heading (i_heading),
        .o_ready   (o_ready),
        .o_valid   (link_valid[0]),
        .o_data    (link_data[0]),
        .i_ready   (link_ready[0])
    );

    // Rotator chain, one micro-rotation per cell
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        gtg_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .i_data  (link_data[k]),
            .o_ready (link_ready[k]),
            .o_valid (link_valid[k+1]),
            .o_data  (link_data[k+1]),
            .i_ready (link_ready[k+1])
        );
    end

    // Scale to distance and bearing, form the commands
    gtg_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (link_valid[CORDIC_STEPS]),
        .i_data        (link_data[CORDIC_STEPS]),
        .o_ready       (link_ready[CORDIC_STEPS]),
        .o_valid       (o_valid),
        .o_linear_cmd  (o_linear_cmd),
        .o_angular_cmd (o_angular_cmd),
        .o_reached     (o_reached),
        .i_ready       (i_ready)
    );

endmodule

`default_nettype wire

/* sv/gtg_prep.sv */
`default_nettype none

module gtg_prep (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gtg_pkg::t_cfg  i_cfg,
    input  wire logic           i_valid,
    input  wire logic [15:0]    i_pos_x,
    input  wire logic [15:0]    i_pos_y,
    input  wire logic [15:0]    i_heading,
    output logic                o_ready,
    output logic                o_valid,
    output gtg_pkg::t_cord      o_data,
    input  wire logic           i_ready
);

    logic                  r_valid;
    gtg_pkg::t_cord        r_data;
    gtg_pkg::t_cord        n_data;
    logic signed [16:0]    dx;
    logic signed [16:0]    dy;
    logic signed [16:0]    ax;
    logic signed [16:0]    ay;
    logic                  neg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Form the goal vector, fold it into the right half plane
    always_comb begin
        dx  = {i_cfg.goal_x[15], i_cfg.goal_x} - {i_pos_x[15], i_pos_x};
        dy  = {i_cfg.goal_y[15], i_cfg.goal_y} - {i_pos_y[15], i_pos_y};
        neg = dx[16];
        ax  = neg ? -dx : dx;
        ay  = neg ? -dy : dy;
        n_data.x  = {{(gtg_pkg::XW-25){ax[16]}}, ax, 8'd0};
        n_data.y  = {{(gtg_pkg::XW-25){ay[16]}}, ay, 8'd0};
        n_data.hd = i_heading;
        if (!neg) begin
            n_data.z = '0;
        end else if (dy[16]) begin
            n_data.z = -gtg_pkg::PI_Q29;
        end else begin
            n_data.z = gtg_pkg::PI_Q29;
        end
    end

    // Take a beat whenever the slot is free or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

/* sv/gtg_cell.sv */
`default_nettype none

module gtg_cell #(
    parameter int unsigned STEP = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire gtg_pkg::t_cord  i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output gtg_pkg::t_cord       o_data,
    input  wire logic            i_ready
);

    logic                         r_valid;
    gtg_pkg::t_cord               r_data;
    gtg_pkg::t_cord               n_data;
    logic signed [gtg_pkg::XW-1:0] xs;
    logic signed [gtg_pkg::XW-1:0] ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // One vectoring micro-rotation, driving y toward zero
    always_comb begin
        xs     = $signed(i_data.x) >>> STEP;
        ys     = $signed(i_data.y) >>> STEP;
        n_data = i_data;
        if (!i_data.y[gtg_pkg::XW-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + gtg_pkg::atan_q29(STEP);
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - gtg_pkg::atan_q29(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

/* sv/gtg_post.sv */
`default_nettype none

module gtg_post (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gtg_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    input  wire gtg_pkg::t_cord  i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [15:0]          o_linear_cmd,
    output logic [15:0]          o_angular_cmd,
    output logic                 o_reached,
    input  wire logic            i_ready
);

    // Stage 1: gain-corrected magnitude product, heading error
    logic                 r1_valid;
    logic [42:0]          r1_prod;
    logic signed [18:0]   r1_err;
    // Stage 2: distance, angular product
    logic                 r2_valid;
    logic [17:0]          r2_dist;
    logic signed [31:0]   r2_angp;
    // Stage 3: linear product, saturated angular command, arrival
    logic                 r3_valid;
    logic [29:0]          r3_linp;
    logic [15:0]          r3_ang;
    logic                 r3_near;
    // Stage 4: output register
    logic                 r4_valid;
    logic [15:0]          r4_lin;
    logic [15:0]          r4_ang;
    logic                 r4_reached;

    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdy4;

    logic [26:0]          xc;
    logic [42:0]          n1_prod;
    logic signed [gtg_pkg::ZW-1:0] zsum;
    logic signed [17:0]   brg;
    logic signed [18:0]   n1_err;
    logic [42:0]          dsum;
    logic [17:0]          n2_dist;
    logic signed [31:0]   n2_angp;
    logic [29:0]          n3_linp;
    logic signed [31:0]   asum;
    logic signed [18:0]   ash;
    logic [15:0]          n3_ang;
    logic                 n3_near;
    logic [30:0]          lsum;
    logic [22:0]          lsh;
    logic [15:0]          n4_lin;

    assign rdy4    = !r4_valid || i_ready;
    assign rdy3    = !r3_valid || rdy4;
    assign rdy2    = !r2_valid || rdy3;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;

    // Clamp x, scale by the inverse of the rotator gain, round the angle to Q3.13
    always_comb begin
        xc      = i_data.x[gtg_pkg::XW-1] ? '0 : i_data.x[26:0];
        n1_prod = {16'd0, xc} * {27'd0, gtg_pkg::GAIN_CORR};
        zsum    = i_data.z + 34'sd32768;
        brg     = zsum[gtg_pkg::ZW-1:16];
        n1_err  = {brg[17], brg} - {{3{i_data.hd[15]}}, i_data.hd};
    end

    // Round the distance, weight the heading error
    always_comb begin
        dsum    = r1_prod + 43'd8388608;
        n2_dist = dsum[41:24];
        n2_angp = $signed({20'd0, i_cfg.angular_gain}) * $signed({{13{r1_err[18]}}, r1_err});
    end

    // Weight the distance, round and clamp the turn command
    always_comb begin
        n3_linp = {18'd0, i_cfg.linear_gain} * {12'd0, r2_dist};
        n3_near = r2_dist <= {2'd0, i_cfg.arrive_tolerance};
        asum    = r2_angp + 32'sd4096;
        ash     = asum[31:13];
        if (ash > 19'sd32767) begin
            n3_ang = 16'h7FFF;
        end else if (ash < -19'sd32768) begin
            n3_ang = 16'h8000;
        end else begin
            n3_ang = ash[15:0];
        end
    end

    // Round and clamp the forward command
    always_comb begin
        lsum = {1'b0, r3_linp} + 31'd128;
        lsh  = lsum[30:8];
        if (lsh > 23'd32767) begin
            n4_lin = 16'h7FFF;
        end else begin
            n4_lin = lsh[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_prod <= n1_prod;
            r1_err  <= n1_err;
        end
        if (rdy2) begin
            r2_dist <= n2_dist;
            r2_angp <= n2_angp;
        end
        if (rdy3) begin
            r3_linp <= n3_linp;
            r3_ang  <= n3_ang;
            r3_near <= n3_near;
        end
        // Zero both commands once the goal is within tolerance
        if (rdy4) begin
            r4_lin     <= r3_near ? 16'd0 : n4_lin;
            r4_ang     <= r3_near ? 16'd0 : r3_ang;
            r4_reached <= r3_near;
        end
    end

    assign o_valid       = r4_valid;
    assign o_linear_cmd  = r4_lin;
    assign o_angular_cmd = r4_ang;
    assign o_reached     = r4_reached;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gtg_pkg::*;

    localparam int unsigned STEPS      = CORDIC_STEPS_DEF;
    localparam int unsigned ATAN_DEPTH = ATAN_LEN;
    localparam int unsigned LATENCY    = STEPS + 5;
    localparam int unsigned STALL_MAX  = 2000;
    localparam int unsigned RAND_PHASES = 12;
    localparam int unsigned CALM_PHASES = 2;
    localparam int unsigned PHASE_ITEMS = 125;

    // Spare register indexes; writes there must be ignored
    localparam logic [2:0] IDX_SPARE_LO = 3'd5;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;

    localparam longint PI_Z      = 64'sd1686629713;
    localparam longint K_INV_Q16 = 64'sd39797;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
        logic               reached;
    } cmd_t;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_wr_en  = 1'b0;
    logic [2:0]  i_cfg_idx    = '0;
    logic [15:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [15:0] i_pos_x      = '0;
    logic [15:0] i_pos_y      = '0;
    logic [15:0] i_heading    = '0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [15:0] o_linear_cmd;
    logic [15:0] o_angular_cmd;
    logic        o_reached;

    // Mirror of the register file, reset values
    logic signed [15:0] goal_x_m   = 16'sd256;
    logic signed [15:0] goal_y_m   = 16'sd256;
    logic [11:0]        lin_gain_m = 12'd384;
    logic [11:0]        ang_gain_m = 12'd1024;
    logic [15:0]        tol_m      = 16'd3;

    pose_t pose_q[$];
    cmd_t  cmd_q[$];

    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_cnt = 0;

    go_to_goal_p_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_heading     (i_heading),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_linear_cmd  (o_linear_cmd),
        .o_angular_cmd (o_angular_cmd),
        .o_reached     (o_reached)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // atan(2^-i) in Q3.29
    function automatic longint arctan_step(input int i);
        case (i)
            0:       return 64'sd421657428;
            1:       return 64'sd248918915;
            2:       return 64'sd131521918;
            3:       return 64'sd66762579;
            4:       return 64'sd33510843;
            5:       return 64'sd16771758;
            6:       return 64'sd8387925;
            7:       return 64'sd4194219;
            8:       return 64'sd2097141;
            9:       return 64'sd1048575;
            10:      return 64'sd524288;
            11:      return 64'sd262144;
            12:      return 64'sd131072;
            13:      return 64'sd65536;
            14:      return 64'sd32768;
            15:      return 64'sd16384;
            16:      return 64'sd8192;
            17:      return 64'sd4096;
            18:      return 64'sd2048;
            19:      return 64'sd1024;
            20:      return 64'sd512;
            21:      return 64'sd256;
            22:      return 64'sd128;
            23:      return 64'sd64;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Distance and bearing by vectoring rotation, then the two P terms
    function automatic cmd_t predict_cmd(input logic [15:0] px_b, input logic [15:0] py_b,
                                         input logic [15:0] hd_b);
        longint px, py, hd, dx, dy, x, y, z, xs, ys, dist_q8, bearing, lin, ang, gx, gy;
        longint lg, ag, tol;
        int     i;
        cmd_t   c;
        px = $signed(px_b);
        py = $signed(py_b);
        hd = $signed(hd_b);
        gx = goal_x_m;
        gy = goal_y_m;
        lg = lin_gain_m;
        ag = ang_gain_m;
        tol = tol_m;
        dx = gx - px;
        dy = gy - py;
        z = 0;
        // Fold the left half plane onto the right one
        if (dx < 0) begin
            z = (dy >= 0) ? PI_Z : -PI_Z;
            dx = -dx;
            dy = -dy;
        end
        x = dx * 256;
        y = dy * 256;
        for (i = 0; i < STEPS && i < ATAN_DEPTH; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
        end
        if (x < 0)
            x = 0;
        dist_q8 = (x * K_INV_Q16 + 64'sd8388608) >>> 24;
        bearing = (z + 64'sd32768) >>> 16;
        if (dist_q8 <= tol) begin
            c.linear_cmd = '0;
            c.angular_cmd = '0;
            c.reached = 1'b1;
        end else begin
            lin = clamp16((lg * dist_q8 + 128) >>> 8);
            ang = clamp16((ag * (bearing - hd) + 4096) >>> 13);
            c.linear_cmd = lin[15:0];
            c.angular_cmd = ang[15:0];
            c.reached = 1'b0;
        end
        return c;
    endfunction

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Pose driver: present the next pending pose, hold it until accepted
    always @(posedge i_clk) begin : pose_drv
        pose_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && o_ready)
                cmd_q.push_back(predict_cmd(i_pos_x, i_pos_y, i_heading));
            if (i_valid && !o_ready) begin
                // hold the beat
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pose_q.size() != 0) begin
                nxt = pose_q.pop_front();
                i_pos_x <= nxt.pos_x;
                i_pos_y <= nxt.pos_y;
                i_heading <= nxt.heading;
                i_valid <= 1'b1;
                if ($urandom_range(99) < send_pct)
                    send_gap <= $urandom_range(13, 1);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Command monitor: check each beat against the oldest prediction
    always @(posedge i_clk) begin : cmd_mon
        cmd_t want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (cmd_q.size() == 0) begin
                    report_error("command beat with no pose pending");
                end else begin
                    want = cmd_q.pop_front();
                    if (o_linear_cmd !== want.linear_cmd)
                        report_error($sformatf("linear_cmd got %0d want %0d",
                            $signed(o_linear_cmd), want.linear_cmd));
                    if (o_angular_cmd !== want.angular_cmd)
                        report_error($sformatf("angular_cmd got %0d want %0d",
                            $signed(o_angular_cmd), want.angular_cmd));
                    if (o_reached !== want.reached)
                        report_error($sformatf("reached got %0b want %0b",
                            o_reached, want.reached));
                end
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                i_ready <= 1'b0;
            end else if ($urandom_range(99) < recv_pct) begin
                recv_stall <= $urandom_range(13, 1) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_GOAL_X:   goal_x_m = data;
            CFG_GOAL_Y:   goal_y_m = data;
            CFG_LIN_GAIN: lin_gain_m = data[11:0];
            CFG_ANG_GAIN: ang_gain_m = data[11:0];
            CFG_TOL:      tol_m = data;
            default:      ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait until no pose is pending and every command has come back
    task automatic wait_idle();
        @(negedge i_clk);
        while (pose_q.size() != 0 || i_valid || cmd_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic push_pose(input logic [15:0] x, input logic [15:0] y, input logic [15:0] h);
        pose_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.heading = h;
        pose_q.push_back(p);
    endtask

    function automatic logic [15:0] pick_edge();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Mostly near-goal and mid-range poses, plus full-range and edge values
    function automatic pose_t rand_pose();
        pose_t p;
        int    off_x, off_y;
        case ($urandom_range(9))
            0, 1, 2: begin
                p.pos_x = $urandom;
                p.pos_y = $urandom;
            end
            3, 4, 5: begin
                off_x = int'($urandom_range(16)) - 8;
                off_y = int'($urandom_range(16)) - 8;
                p.pos_x = goal_x_m + off_x[15:0];
                p.pos_y = goal_y_m + off_y[15:0];
            end
            6: begin
                p.pos_x = pick_edge();
                p.pos_y = pick_edge();
            end
            default: begin
                off_x = int'($urandom_range(4096)) - 2048;
                off_y = int'($urandom_range(4096)) - 2048;
                p.pos_x = goal_x_m + off_x[15:0];
                p.pos_y = goal_y_m + off_y[15:0];
            end
        endcase
        if ($urandom_range(4) == 0)
            p.heading = $urandom;
        else
            p.heading = 16'(int'($urandom_range(51472)) - 25736);
        return p;
    endfunction

    initial begin : stim
        logic [15:0] tol_v;
        int          ph;
        int          n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values: on the goal, both half planes, axis cases, edges
        push_pose(16'sd256, 16'sd256, 16'sd0);
        push_pose(16'sd257, 16'sd256, 16'sd0);
        push_pose(16'h8000, 16'h8000, 16'sd25736);
        push_pose(16'h7fff, 16'h7fff, -16'sd25736);
        push_pose(16'h7fff, 16'h8000, 16'h8000);
        push_pose(16'h8000, 16'h7fff, 16'h7fff);
        push_pose(16'sd256, -16'sd1000, 16'sd0);
        push_pose(16'sd256, 16'sd2000, 16'sd0);
        push_pose(16'sd1000, 16'sd0, 16'sd0);
        push_pose(16'sd1000, 16'sd1000, 16'sd0);
        push_pose(16'sd0, 16'sd0, 16'sd12868);
        push_pose(16'sd256, 16'sd253, 16'sd0);
        push_pose(16'sd256, 16'sd252, 16'sd0);
        wait_idle();

        // Top gains, zero tolerance: saturation on both commands
        cfg_write(CFG_GOAL_X, 16'h7fff);
        cfg_write(CFG_GOAL_Y, 16'h8000);
        cfg_write(CFG_LIN_GAIN, 16'h0fff);
        cfg_write(CFG_ANG_GAIN, 16'hffff);
        cfg_write(CFG_TOL, 16'h0000);
        @(negedge i_clk);
        push_pose(16'h7fff, 16'h8000, 16'sd0);
        push_pose(16'h8000, 16'h7fff, -16'sd25736);
        push_pose(16'h8000, 16'h8000, 16'sd25736);
        push_pose(16'h7fff, 16'h7fff, 16'h8000);
        wait_idle();

        // Zero gains, widest tolerance
        cfg_write(CFG_GOAL_X, 16'h8000);
        cfg_write(CFG_GOAL_Y, 16'h7fff);
        cfg_write(CFG_LIN_GAIN, 16'hf000);
        cfg_write(CFG_ANG_GAIN, 16'h0000);
        cfg_write(CFG_TOL, 16'hffff);
        @(negedge i_clk);
        push_pose(16'h8000, 16'h7fff, 16'sd0);
        push_pose(16'h7fff, 16'h8000, 16'sd0);
        push_pose(16'sd0, 16'sd0, 16'sd0);
        wait_idle();

        // Random settings and poses; the last phases run with no send gaps or receive stalls
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            cfg_write(CFG_GOAL_X, ($urandom_range(3) == 0) ? pick_edge() : 16'($urandom));
            cfg_write(CFG_GOAL_Y, ($urandom_range(3) == 0) ? pick_edge() : 16'($urandom));
            cfg_write(CFG_LIN_GAIN, ($urandom_range(4) == 0) ?
                      {4'($urandom), ($urandom_range(1) ? 12'hfff : 12'h000)} : 16'($urandom));
            cfg_write(CFG_ANG_GAIN, ($urandom_range(4) == 0) ?
                      {4'($urandom), ($urandom_range(1) ? 12'hfff : 12'h000)} : 16'($urandom));
            case ($urandom_range(5))
                0, 1, 2, 3: tol_v = 16'($urandom_range(64));
                4:          tol_v = 16'($urandom);
                default:    tol_v = $urandom_range(1) ? 16'hffff : 16'h0000;
            endcase
            cfg_write(CFG_TOL, tol_v);
            cfg_write(3'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO)), 16'($urandom));
            @(negedge i_clk);
            if (ph >= RAND_PHASES - CALM_PHASES) begin
                send_pct = 0;
                recv_pct = 0;
            end else begin
                send_pct = pick_pct();
                recv_pct = pick_pct();
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                pose_q.push_back(rand_pose());
            wait_idle();
        end

        // Let any stray beat show up before the verdict
        repeat (2 * LATENCY) @(negedge i_clk);
        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* files.f */
sv/gtg_pkg.sv
sv/gtg_prep.sv
sv/gtg_cell.sv
sv/gtg_post.sv
sv/go_to_goal_p_controller.sv
tb/tb_top.sv
